// ----- rtl/fti_pkg.sv -----
// ============================================================================
// fti_pkg: shared types and constants for the frame-tagged input history
// Beat structs for the input and result channels, command codes, defaults.
// ============================================================================
package fti_pkg;

    localparam int MAX_SLOTS_DEF = 128;

    localparam logic [1:0] CMD_STORE_PRED = 2'd0;
    localparam logic [1:0] CMD_STORE_CONF = 2'd1;
    localparam logic [1:0] CMD_READ_PRED  = 2'd2;
    localparam logic [1:0] CMD_READ_CONF  = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        frame;
        logic [7:0]         player_num;
        logic [31:0]        buttons;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
    } fti_in_t;

    typedef struct packed {
        logic               predicted_present;
        logic               confirmed_present;
        logic               prediction_ok;
        logic [7:0]         out_player;
        logic [31:0]        out_buttons;
        logic signed [15:0] out_left_x;
        logic signed [15:0] out_left_y;
        logic signed [15:0] out_right_x;
        logic signed [15:0] out_right_y;
        logic [31:0]        oldest_seen;
        logic [31:0]        newest_seen;
    } fti_out_t;

endpackage

// ----- rtl/frame_tagged_input_history_core.sv -----
// Path from input beat to result: 32-step frame % capacity, memory read,
//   compare/write-back, result register; when disabled, no division or memory access.
// Items: one at a time, paced by the serial remainder unit; a result not yet
//   taken holds the next item.
// Reset: capacity 0 (disabled), window cleared. After reset or a capacity
//   write, a clearing pass over all MAX_SLOTS entries empties tags and flags.
// ============================================================================
// frame_tagged_input_history_core: frame-keyed history table of input records
// Tag/flag and record memories, read-modify-write per item, serial modulo.
// ============================================================================
module frame_tagged_input_history_core
    import fti_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic     s_valid,
    output logic     s_ready,
    input  fti_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output fti_out_t m_data
);
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_SLOTS);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]    state_reg;
    logic [CW-1:0] cap_reg;
    logic [AW:0]   clr_cnt_reg;
    logic [4:0]    div_cnt_reg;
    logic [CW:0]   rem_reg;
    fti_in_t       item_reg;
    logic [AW-1:0] slot_reg;
    logic [31:0]   win_lo_reg, win_hi_reg;
    logic          win_ok_reg;
    fti_out_t      out_reg;
    logic          out_valid_reg;

    // memories: tag+flags, and two record stores
    logic [33:0] tf_mem [MAX_SLOTS];
    logic [103:0] pred_mem [MAX_SLOTS];
    logic [103:0] conf_mem [MAX_SLOTS];
    logic [33:0]  tf_q;
    logic [103:0] pred_q, conf_q;

    logic [CW-1:0] cfg_clamped;
    always_comb begin
        if (cfg_wdata == 8'd0)
            cfg_clamped = CW'(1);
        else if (32'(cfg_wdata) > 32'(MAX_SLOTS))
            cfg_clamped = MAXC;
        else
            cfg_clamped = CW'(cfg_wdata);
    end

    assign s_ready = (state_reg == ST_IDLE) && !cfg_we;
    wire in_fire = s_valid && s_ready;

    // remainder step: shift in one frame bit, subtract capacity if it fits
    logic [CW:0] rem_sh;
    assign rem_sh = {rem_reg[CW-1:0], item_reg.frame[5'd31 - div_cnt_reg]};

    // record fields
    wire [103:0] rec_in = {item_reg.player_num, item_reg.buttons, item_reg.right_y,
                           item_reg.right_x, item_reg.left_y, item_reg.left_x};

    // update logic
    logic        tag_hit, is_store, has_p, has_c, hit;
    logic [1:0]  flags_new;
    logic [103:0] p_rec, c_rec, r_rec;
    logic [31:0] lo_n, hi_n, lo_w;
    logic [32:0] width;
    always_comb begin
        is_store  = (item_reg.command == CMD_STORE_PRED) ||
                    (item_reg.command == CMD_STORE_CONF);
        tag_hit   = tf_q[33:2] == item_reg.frame;
        flags_new = tag_hit ? tf_q[1:0] : 2'b00;
        p_rec = pred_q;
        c_rec = conf_q;
        if (is_store) begin
            if (item_reg.command == CMD_STORE_PRED) begin
                flags_new[0] = 1'b1;
                p_rec = rec_in;
            end else begin
                flags_new[1] = 1'b1;
                c_rec = rec_in;
            end
        end
        hit   = (is_store || tag_hit) && flags_new != 2'b00;
        has_p = hit && flags_new[0];
        has_c = hit && flags_new[1];
        r_rec = '0;
        if (item_reg.command == CMD_READ_PRED && has_p) r_rec = p_rec;
        if (item_reg.command == CMD_READ_CONF && has_c) r_rec = c_rec;
        // window
        lo_n = win_lo_reg;
        hi_n = win_hi_reg;
        if (!win_ok_reg) begin
            lo_n = item_reg.frame;
            hi_n = item_reg.frame;
        end else begin
            if (item_reg.frame < lo_n) lo_n = item_reg.frame;
            if (item_reg.frame > hi_n) hi_n = item_reg.frame;
        end
        width = {1'b0, hi_n - lo_n} + 33'd1;
        lo_w  = lo_n;
        if (width > 33'(cap_reg))
            lo_w = hi_n - 32'(cap_reg) + 32'd1;
    end

    wire disabled = (cap_reg == '0);
    // result register free for a new beat at this edge
    wire out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            cap_reg       <= '0;
            clr_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            win_ok_reg    <= 1'b0;
            win_lo_reg    <= '0;
            win_hi_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we) begin
                cap_reg     <= cfg_clamped;
                win_ok_reg  <= 1'b0;
                win_lo_reg  <= '0;
                win_hi_reg  <= '0;
                clr_cnt_reg <= '0;
                state_reg   <= ST_CLR;
            end else begin
                unique case (state_reg)
                    ST_CLR: begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                        if (clr_cnt_reg == (AW+1)'(MAX_SLOTS - 1))
                            state_reg <= ST_IDLE;
                    end
                    ST_IDLE: begin
                        if (in_fire) begin
                            item_reg    <= s_data;
                            rem_reg     <= '0;
                            div_cnt_reg <= '0;
                            state_reg   <= ST_DIV;
                        end
                    end
                    ST_DIV: begin
                        if (disabled) begin
                            if (out_free)
                                state_reg <= ST_OUT;
                        end else begin
                            rem_reg <= (rem_sh >= {1'b0, cap_reg}) ?
                                       rem_sh - {1'b0, cap_reg} : rem_sh;
                            div_cnt_reg <= div_cnt_reg + 1'b1;
                            if (div_cnt_reg == 5'd31) state_reg <= ST_RD;
                        end
                    end
                    ST_RD: begin
                        slot_reg <= AW'(rem_reg);
                        // wait here while the previous result is still held
                        if (out_free)
                            state_reg <= ST_UPD;
                    end
                    ST_UPD: begin
                        state_reg <= ST_OUT;
                    end
                    ST_OUT: begin
                        if (!out_valid_reg || m_ready) begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                    end
                    default: state_reg <= ST_IDLE;
                endcase
                if (state_reg == ST_UPD && is_store) begin
                    win_ok_reg <= 1'b1;
                    win_lo_reg <= lo_w;
                    win_hi_reg <= hi_n;
                end
            end
        end
    end

    // memory access: read on ST_RD, write on ST_UPD for stores or clear pass
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD) begin
            tf_q   <= tf_mem[AW'(rem_reg)];
            pred_q <= pred_mem[AW'(rem_reg)];
            conf_q <= conf_mem[AW'(rem_reg)];
        end
        if (state_reg == ST_CLR)
            tf_mem[clr_cnt_reg[AW-1:0]] <= '0;
        else if (state_reg == ST_UPD && is_store) begin
            tf_mem[slot_reg] <= {item_reg.frame, flags_new};
            if (item_reg.command == CMD_STORE_PRED)
                pred_mem[slot_reg] <= rec_in;
            else
                conf_mem[slot_reg] <= rec_in;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_UPD) begin
            out_reg.predicted_present <= has_p;
            out_reg.confirmed_present <= has_c;
            out_reg.prediction_ok     <= has_p && has_c && (p_rec == c_rec);
            out_reg.out_player        <= r_rec[103:96];
            out_reg.out_buttons       <= r_rec[95:64];
            out_reg.out_right_y       <= r_rec[63:48];
            out_reg.out_right_x       <= r_rec[47:32];
            out_reg.out_left_y        <= r_rec[31:16];
            out_reg.out_left_x        <= r_rec[15:0];
            out_reg.oldest_seen       <= is_store ? lo_w : win_lo_reg;
            out_reg.newest_seen       <= is_store ? hi_n : win_hi_reg;
        end else if (state_reg == ST_DIV && disabled && out_free) begin
            // disabled: miss, window unchanged
            out_reg.predicted_present <= 1'b0;
            out_reg.confirmed_present <= 1'b0;
            out_reg.prediction_ok     <= 1'b0;
            out_reg.out_player        <= '0;
            out_reg.out_buttons       <= '0;
            out_reg.out_right_y       <= '0;
            out_reg.out_right_x       <= '0;
            out_reg.out_left_y        <= '0;
            out_reg.out_left_x        <= '0;
            out_reg.oldest_seen       <= win_lo_reg;
            out_reg.newest_seen       <= win_hi_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // checks
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLR |-> !s_ready) else $error("accept during clear");
    a_cap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cap_reg <= MAXC) else $error("capacity out of range");
    a_window_order: assert property (@(posedge aclk) disable iff (!aresetn)
        win_ok_reg |-> win_lo_reg <= win_hi_reg) else $error("window inverted");
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RD |-> rem_reg < {1'b0, cap_reg}) else $error("bad slot");

endmodule

// ----- tb/frame_tagged_input_history_core_tb.sv -----
// ============================================================================
// frame_tagged_input_history_core_tb: self-checking bench for the history core
// Drives command beats through a valid/ready driver, predicts each result
// beat with a behavioral table model and compares the whole beat against it.
// ============================================================================
module frame_tagged_input_history_core_tb;
    import fti_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 128;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES = 80;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     cfg_we = 1'b0;
    logic [7:0] cfg_wdata = '0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    fti_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    fti_out_t m_data;

    // predictor state
    int unsigned  cap_q;
    logic [31:0]  tag_q [SLOTS];
    logic [1:0]   flag_q [SLOTS];
    logic [39:0]  guess_id_q [SLOTS];
    logic [63:0]  guess_ax_q [SLOTS];
    logic [39:0]  final_id_q [SLOTS];
    logic [63:0]  final_ax_q [SLOTS];
    logic [31:0]  win_lo_q, win_hi_q;
    logic         win_ok_q;

    fti_in_t  pending_beats [$];
    fti_out_t expected_results [$];
    int       errors = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       recv_hold = 0;
    int       quiet_cycles = 0;
    logic [31:0] frame_base;

    frame_tagged_input_history_core u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #10 aclk = ~aclk;

    function automatic void table_clear();
        for (int i = 0; i < SLOTS; i++) begin
            tag_q[i] = '0;
            flag_q[i] = '0;
        end
        win_lo_q = '0;
        win_hi_q = '0;
        win_ok_q = 1'b0;
    endfunction

    function automatic void capacity_set(logic [7:0] v);
        int unsigned c;
        c = v;
        table_clear();
        if (c < 1) c = 1;
        if (c > SLOTS) c = SLOTS;
        cap_q = c;
    endfunction

    // history table update and lookup for one command beat
    function automatic fti_out_t history_predict(fti_in_t b);
        fti_out_t r;
        int unsigned s;
        logic [39:0] idb;
        logic [63:0] ax;
        logic hit, hp, hc;
        r = '0;
        s = 0;
        hit = 1'b0;
        idb = {b.player_num, b.buttons};
        ax = {b.right_y, b.right_x, b.left_y, b.left_x};
        if (cap_q != 0) begin
            s = b.frame % cap_q;
            if (b.command == CMD_STORE_PRED || b.command == CMD_STORE_CONF) begin
                if (tag_q[s] != b.frame) begin
                    tag_q[s] = b.frame;
                    flag_q[s] = '0;
                end
                if (b.command == CMD_STORE_PRED) begin
                    guess_id_q[s] = idb;
                    guess_ax_q[s] = ax;
                    flag_q[s][0] = 1'b1;
                end else begin
                    final_id_q[s] = idb;
                    final_ax_q[s] = ax;
                    flag_q[s][1] = 1'b1;
                end
                // widen window, then trim the low end to capacity
                if (!win_ok_q) begin
                    win_lo_q = b.frame;
                    win_hi_q = b.frame;
                    win_ok_q = 1'b1;
                end else begin
                    if (b.frame < win_lo_q) win_lo_q = b.frame;
                    if (b.frame > win_hi_q) win_hi_q = b.frame;
                    if ({32'd0, win_hi_q - win_lo_q} + 64'd1 > 64'(cap_q))
                        win_lo_q = win_hi_q - cap_q + 1;
                end
            end
            hit = (tag_q[s] == b.frame) && (flag_q[s] != 0);
        end
        if (hit) begin
            hp = flag_q[s][0];
            hc = flag_q[s][1];
            r.predicted_present = hp;
            r.confirmed_present = hc;
            r.prediction_ok = hp && hc && guess_id_q[s] == final_id_q[s]
                              && guess_ax_q[s] == final_ax_q[s];
            if (b.command == CMD_READ_PRED && hp)
                {r.out_player, r.out_buttons} = guess_id_q[s];
            else if (b.command == CMD_READ_CONF && hc)
                {r.out_player, r.out_buttons} = final_id_q[s];
            if (b.command == CMD_READ_PRED && hp)
                {r.out_right_y, r.out_right_x, r.out_left_y, r.out_left_x} =
                    guess_ax_q[s];
            else if (b.command == CMD_READ_CONF && hc)
                {r.out_right_y, r.out_right_x, r.out_left_y, r.out_left_x} =
                    final_ax_q[s];
        end
        r.oldest_seen = win_lo_q;
        r.newest_seen = win_hi_q;
        return r;
    endfunction

    function automatic fti_in_t beat_make(logic [1:0] c, logic [31:0] f);
        fti_in_t b;
        b.command = c;
        b.frame = f;
        b.player_num = 8'($urandom);
        b.buttons = $urandom;
        b.left_x = 16'($urandom);
        b.left_y = 16'($urandom);
        b.right_x = 16'($urandom);
        b.right_y = 16'($urandom);
        return b;
    endfunction

    // driver: one beat at a time from the pending queue
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(history_predict(s_data));
            end
            if ((!s_valid || s_ready) && pending_beats.size() > 0
                    && $urandom_range(99, 0) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= pending_beats.pop_front();
            end else if (s_valid && s_ready) begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver ready with random stalls and an optional long hold-off
    always @(posedge aclk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        fti_out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_data);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_data !== exp_r) begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, m_data);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("frame_tagged_input_history_core verification failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_beats.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        capacity_set(v);
        // table clearing pass
        repeat (SLOTS + 8) @(posedge aclk);
    endtask

    // well-formed random traffic around a moving frame base
    task automatic random_phase(int n, logic [7:0] capv);
        logic [31:0] f;
        int k;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(9, 0))
                0: f = $urandom;
                1: f = frame_base - $urandom_range(300, 0);
                default: f = frame_base + $urandom_range(2 * capv + 4, 0);
            endcase
            if ($urandom_range(3, 0) == 0) frame_base += $urandom_range(3, 1);
            if ($urandom_range(2, 0) == 0 && pending_beats.size() > 0
                    && pending_beats[$].command == CMD_STORE_PRED) begin
                // confirm the last prediction, often unchanged
                pending_beats.push_back(pending_beats[$]);
                pending_beats[$].command = CMD_STORE_CONF;
                if ($urandom_range(1, 0))
                    pending_beats[$].buttons ^= 32'h1 << $urandom_range(31, 0);
            end else begin
                pending_beats.push_back(beat_make(2'($urandom), f));
            end
        end
    endtask

    initial begin
        fti_in_t b;
        cap_q = 0;
        table_clear();
        frame_base = 32'd1000;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (SLOTS + 8) @(posedge aclk);

        // disabled: stores are no-ops, reads miss
        pending_beats.push_back(beat_make(CMD_STORE_PRED, 32'd5));
        pending_beats.push_back(beat_make(CMD_READ_PRED, 32'd5));
        pending_beats.push_back(beat_make(CMD_READ_CONF, 32'd0));
        wait_idle();

        // directed: extremes, all commands, full-range window
        write_capacity(8'd4);
        b = beat_make(CMD_STORE_PRED, 32'd0);
        b.player_num = 8'hFF; b.buttons = '1;
        b.left_x = 16'sh8000; b.left_y = 16'sh7FFF; b.right_x = '1; b.right_y = '0;
        pending_beats.push_back(b);
        b.command = CMD_STORE_CONF;
        pending_beats.push_back(b);
        pending_beats.push_back(beat_make(CMD_READ_PRED, 32'd0));
        pending_beats.push_back(beat_make(CMD_READ_CONF, 32'd0));
        pending_beats.push_back(beat_make(CMD_STORE_CONF, 32'hFFFF_FFFF));
        pending_beats.push_back(beat_make(CMD_READ_CONF, 32'hFFFF_FFFF));
        pending_beats.push_back(beat_make(CMD_READ_PRED, 32'd4));
        pending_beats.push_back(beat_make(CMD_STORE_PRED, 32'd4));
        pending_beats.push_back(beat_make(CMD_READ_CONF, 32'd4));
        pending_beats.push_back(beat_make(CMD_READ_PRED, 32'd8));
        b = beat_make(CMD_STORE_PRED, 32'd9);
        b.player_num = '0; b.buttons = '0; b.left_x = '0; b.left_y = '0;
        pending_beats.push_back(b);
        wait_idle();

        // write value 0 clamps to 1; oversized clamps to max
        write_capacity(8'd0);
        pending_beats.push_back(beat_make(CMD_STORE_PRED, 32'd7));
        pending_beats.push_back(beat_make(CMD_STORE_CONF, 32'd3));
        pending_beats.push_back(beat_make(CMD_READ_PRED, 32'd7));
        wait_idle();
        write_capacity(8'hFF);
        pending_beats.push_back(beat_make(CMD_STORE_PRED, 32'd200));
        pending_beats.push_back(beat_make(CMD_READ_PRED, 32'd200));
        wait_idle();

        // random phases with shifting idle patterns
        send_idle_pct = 38; recv_idle_pct = 78;
        write_capacity(8'd8);
        random_phase(450, 8'd8);
        recv_hold = 600;
        wait_idle();
        send_idle_pct = 78; recv_idle_pct = 38;
        write_capacity(8'd128);
        random_phase(450, 8'd128);
        wait_idle();
        send_idle_pct = 0; recv_idle_pct = 0;
        write_capacity(8'd3);
        random_phase(300, 8'd3);
        wait_idle();
        write_capacity(8'd1);
        random_phase(300, 8'd1);
        wait_idle();

        if (errors == 0) begin
            $display("frame_tagged_input_history_core verification clean");
        end else begin
            $display("frame_tagged_input_history_core verification failed");
        end
        $finish;
    end

endmodule
